### rtl/bdh_pkg.sv
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types and codes for the button debounce and hold detector.
// ----------------------------------------------------------------------------
package bdh_pkg;

    localparam int CNT_W = 16;
    localparam int OP_W  = 2;

    localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(5);
    localparam logic [CNT_W-1:0] HOLD_RESET     = CNT_W'(100);

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FORCE = 2'd2;

    // configuration register indexes
    localparam logic CFG_DEBOUNCE = 1'b0;
    localparam logic CFG_HOLD     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_PRESSED  = 2'd1,
        ST_HELD     = 2'd2,
        ST_RELEASED = 2'd3
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pin;
        logic [1:0]      forced;
    } t_item;

endpackage

### rtl/bdh_core.sv
// ----------------------------------------------------------------------------
// bdh_core
// Press state and tick counter; applies one word per step.
// ----------------------------------------------------------------------------
module bdh_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  bdh_pkg::t_item           i_item,
    input  logic [bdh_pkg::CNT_W-1:0] i_debounce,
    input  logic [bdh_pkg::CNT_W-1:0] i_hold,
    output bdh_pkg::t_state          o_report
);

    bdh_pkg::t_state             r_state, n_state;
    logic [bdh_pkg::CNT_W-1:0]   r_count, n_count;
    logic [bdh_pkg::CNT_W-1:0]   clamped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdh_pkg::ST_IDLE;
            r_count <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        clamped  = (r_count > i_debounce) ? i_debounce : r_count;
        o_report = r_state;
        case (i_item.op)
            bdh_pkg::OP_TICK: begin
                if (r_state == bdh_pkg::ST_IDLE || r_state == bdh_pkg::ST_RELEASED) begin
                    if (i_item.pin) begin
                        if (r_count != bdh_pkg::CNT_MAX) n_count = r_count + 1'b1;
                    end else begin
                        n_count = '0;
                    end
                    if (n_count >= i_debounce) n_state = bdh_pkg::ST_PRESSED;
                end else begin
                    if (i_item.pin) begin
                        if (r_count < i_hold) n_count = r_count + 1'b1;
                    end else begin
                        n_count = (clamped != '0) ? clamped - 1'b1 : clamped;
                    end
                    if (n_count == i_hold) n_state = bdh_pkg::ST_HELD;
                    // release wins over hold
                    if (n_count == '0)     n_state = bdh_pkg::ST_RELEASED;
                end
                o_report = n_state;
            end
            bdh_pkg::OP_READ: begin
                if (r_state == bdh_pkg::ST_RELEASED) n_state = bdh_pkg::ST_IDLE;
            end
            bdh_pkg::OP_FORCE: begin
                n_state  = bdh_pkg::t_state'(i_item.forced);
                n_count  = '0;
                o_report = n_state;
            end
            default: ;  // unused code: no change
        endcase
    end

endmodule

### rtl/button_debounce_hold_detector_top.sv
// ----------------------------------------------------------------------------
// button_debounce_hold_detector_top
// Button debouncer with long-press detection behind valid/stall channels.
// ----------------------------------------------------------------------------
// Every input word gives exactly one status word, in order. A word is taken
// into an input register and applied to the press state as it moves on into
// an output register, where its status lands. One word per cycle is
// sustained: the input stalls only while both registers are full and the
// output is stalled. Configuration (debounce and hold times) is written
// through the plain write port; the user must do so while no word is in
// flight, as the block itself does not enforce it.
module button_debounce_hold_detector_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input words
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [bdh_pkg::OP_W-1:0]  i_operation,
    input  logic                      i_pin_pressed,
    input  logic [1:0]                i_forced_state,
    // status words
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_button_status,
    // configuration
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bdh_pkg::CNT_W-1:0] i_cfg_data
);

    logic                      r_in_valid;
    bdh_pkg::t_item            r_item;
    logic                      r_out_valid;
    bdh_pkg::t_state           r_status;
    logic [bdh_pkg::CNT_W-1:0] r_debounce;
    logic [bdh_pkg::CNT_W-1:0] r_hold;

    bdh_pkg::t_state           report;
    logic                      advance;   // input register moves to output
    logic                      take;      // new word accepted

    // output register free or being emptied this cycle
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign take       = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= bdh_pkg::DEBOUNCE_RESET;
            r_hold     <= bdh_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdh_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                bdh_pkg::CFG_HOLD:     r_hold     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!r_in_valid || advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.op     <= i_operation;
            r_item.pin    <= i_pin_pressed;
            r_item.forced <= i_forced_state;
        end
    end

    // state update happens as the word leaves the input register
    bdh_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_item     (r_item),
        .i_debounce (r_debounce),
        .i_hold     (r_hold),
        .o_report   (report)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= report;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_button_status = r_status;

endmodule

### rtl/bdh_checker.sv
// ----------------------------------------------------------------------------
// bdh_checker
// Port-level checks for the debounce and hold detector.
// ----------------------------------------------------------------------------
module bdh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_button_status
);

    // no status word right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("status word valid after reset");

    // input only backs up behind a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    // a word accepted into an empty block reaches the output through the input and output registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid && $past(!i_in_valid || o_in_stall)
         && $past(i_rst_n)) |=> ##1 o_out_valid)
        else $error("status word missing");

    // stalled status word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_button_status)))
        else $error("stalled status word changed");

endmodule

bind button_debounce_hold_detector_top bdh_checker u_bdh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_button_status (o_button_status)
);
